@@ rtl/core/hale_pkg.sv @@
// Shared types, character codes and mnemonic lookup tables for the line encoder.
package hale_pkg;

	localparam int TOK_LEN_W = 4;
	localparam int QDEPTH = 2;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] C_PREFIX = 3'b111;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_A     = 2'd1,
		KIND_C     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_DEST = 2'd0,
		PH_COMP = 2'd1,
		PH_JUMP = 2'd2
	} phase_t;

	// one filtered word from the front end to the parser
	typedef struct packed {
		logic       eol;
		logic       slash;
		logic       chr;
		logic [7:0] ch;
	} ev_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] code;
	} lookup_t;

	// key: token length, then up to three characters (unused ones are zero)
	function automatic logic [27:0] tok_key(input logic [TOK_LEN_W-1:0] len,
			input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
		return {len, c0, c1, c2};
	endfunction

	function automatic lookup_t comp_lookup(input logic [27:0] key);
		lookup_t r;
		r.hit = 1'b1;
		unique case (key)
			{4'd1, "0",   16'h0}: r.code = 7'h2A;
			{4'd1, "1",   16'h0}: r.code = 7'h3F;
			{4'd2, "-1",  8'h0}:  r.code = 7'h3A;
			{4'd1, "D",   16'h0}: r.code = 7'h0C;
			{4'd1, "A",   16'h0}: r.code = 7'h30;
			{4'd2, "!D",  8'h0}:  r.code = 7'h0D;
			{4'd2, "!A",  8'h0}:  r.code = 7'h31;
			{4'd2, "-D",  8'h0}:  r.code = 7'h0F;
			{4'd2, "-A",  8'h0}:  r.code = 7'h33;
			{4'd3, "D+1"}:        r.code = 7'h1F;
			{4'd3, "A+1"}:        r.code = 7'h37;
			{4'd3, "D-1"}:        r.code = 7'h0E;
			{4'd3, "A-1"}:        r.code = 7'h32;
			{4'd3, "D+A"}:        r.code = 7'h02;
			{4'd3, "D-A"}:        r.code = 7'h13;
			{4'd3, "A-D"}:        r.code = 7'h07;
			{4'd3, "D&A"}:        r.code = 7'h00;
			{4'd3, "D|A"}:        r.code = 7'h15;
			{4'd1, "M",   16'h0}: r.code = 7'h70;
			{4'd2, "!M",  8'h0}:  r.code = 7'h71;
			{4'd2, "-M",  8'h0}:  r.code = 7'h73;
			{4'd3, "M+1"}:        r.code = 7'h77;
			{4'd3, "M-1"}:        r.code = 7'h72;
			{4'd3, "D+M"}:        r.code = 7'h42;
			{4'd3, "D-M"}:        r.code = 7'h53;
			{4'd3, "M-D"}:        r.code = 7'h47;
			{4'd3, "D&M"}:        r.code = 7'h40;
			{4'd3, "D|M"}:        r.code = 7'h55;
			default: begin
				r.hit  = 1'b0;
				r.code = 7'h00;
			end
		endcase
		return r;
	endfunction

	function automatic lookup_t dest_lookup(input logic [27:0] key);
		lookup_t r;
		r.hit = 1'b1;
		unique case (key)
			{4'd0, 24'h0}:        r.code = 7'd0;
			{4'd1, "M",   16'h0}: r.code = 7'd1;
			{4'd1, "D",   16'h0}: r.code = 7'd2;
			{4'd2, "MD",  8'h0}:  r.code = 7'd3;
			{4'd1, "A",   16'h0}: r.code = 7'd4;
			{4'd2, "AM",  8'h0}:  r.code = 7'd5;
			{4'd2, "AD",  8'h0}:  r.code = 7'd6;
			{4'd3, "AMD"}:        r.code = 7'd7;
			default: begin
				r.hit  = 1'b0;
				r.code = 7'd0;
			end
		endcase
		return r;
	endfunction

	function automatic lookup_t jump_lookup(input logic [27:0] key);
		lookup_t r;
		r.hit = 1'b1;
		unique case (key)
			{4'd0, 24'h0}: r.code = 7'd0;
			{4'd3, "JGT"}: r.code = 7'd1;
			{4'd3, "JEQ"}: r.code = 7'd2;
			{4'd3, "JGE"}: r.code = 7'd3;
			{4'd3, "JLT"}: r.code = 7'd4;
			{4'd3, "JNE"}: r.code = 7'd5;
			{4'd3, "JLE"}: r.code = 7'd6;
			{4'd3, "JMP"}: r.code = 7'd7;
			default: begin
				r.hit  = 1'b0;
				r.code = 7'd0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/hale_front.sv @@
// Front end: strips comments and whitespace, turns characters into parser words.
module hale_front
	import hale_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] ch,
	input  logic       ends_line,
	output logic       ev_valid,
	output ev_t        ev
);

	logic in_comment_q, slash_pending_q;
	logic in_comment_d, slash_pending_d;
	logic is_ws, is_slash;

	assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_slash = (ch == CH_SLASH);

	always_comb begin
		in_comment_d    = in_comment_q;
		slash_pending_d = slash_pending_q;
		ev              = '0;
		ev.ch           = ch;
		if (ends_line) begin
			ev.eol          = 1'b1;
			ev.slash        = slash_pending_q;
			in_comment_d    = 1'b0;
			slash_pending_d = 1'b0;
		end else if (!in_comment_q) begin
			if (slash_pending_q && is_slash) begin
				in_comment_d    = 1'b1;
				slash_pending_d = 1'b0;
			end else begin
				// a held slash that did not start a comment is an ordinary char
				ev.slash        = slash_pending_q;
				slash_pending_d = is_slash;
				ev.chr          = !is_slash && !is_ws;
			end
		end
	end

	assign ev_valid = in_valid && in_ready && (ev.eol || ev.slash || ev.chr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q    <= 1'b0;
			slash_pending_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_comment_q    <= in_comment_d;
			slash_pending_q <= slash_pending_d;
		end
	end

	a_comment_no_slash: assert property (@(posedge clk) disable iff (!arst_n)
		in_comment_q |-> !slash_pending_q)
		else $error("slash pending while inside a comment");

endmodule

@@ rtl/core/hale_queue.sv @@
// Short queue between the front end and the parser.
module hale_queue
	import hale_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ev_t  in_ev,
	output logic out_valid,
	input  logic out_ready,
	output ev_t  out_ev
);

	ev_t        mem_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'(QDEPTH));
	assign out_valid = (count_q != 2'd0);
	assign out_ev    = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

@@ rtl/core/hale_back.sv @@
// Parser and encoder: builds tokens, decodes mnemonics, emits one word per non-empty line.
module hale_back
	import hale_pkg::*;
#(
	parameter int MAX_TOKEN = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	output logic        ev_ready,
	input  ev_t         ev,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_word,
	output logic        out_error
);

	localparam int LEN_W = $clog2(MAX_TOKEN + 1);
	localparam int IDX_W = $clog2(MAX_TOKEN);

	typedef struct packed {
		kind_t                       kind;
		phase_t                      phase;
		logic [14:0]                 addr;
		logic [MAX_TOKEN-1:0][7:0]   tok;
		logic [LEN_W-1:0]            len;
		logic                        ovf;
		logic [2:0]                  dest;
		logic [6:0]                  comp;
		logic                        err;
	} pst_t;

	function automatic logic [27:0] key_of(pst_t s);
		return tok_key(TOK_LEN_W'(s.len), s.tok[0], s.tok[1], s.tok[2]);
	endfunction

	function automatic pst_t put_char(pst_t s, logic [7:0] c);
		pst_t    r;
		lookup_t lk;
		r = s;
		if (s.kind == KIND_EMPTY && c == CH_AT) begin
			r.kind = KIND_A;
		end else if (s.kind == KIND_A) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				// addr * 10 + digit, wrapping at 15 bits
				r.addr = {s.addr[11:0], 3'b000} + {s.addr[13:0], 1'b0} + {11'b0, c[3:0]};
				r.len  = LEN_W'(1);
			end else begin
				r.err = 1'b1;
			end
		end else begin
			r.kind = KIND_C;
			if (c == CH_EQ) begin
				if (s.phase == PH_DEST) begin
					lk      = dest_lookup(key_of(s));
					r.dest  = (lk.hit && !s.ovf) ? lk.code[2:0] : 3'd0;
					r.err   = s.err | !(lk.hit && !s.ovf);
					r.phase = PH_COMP;
					r.tok   = '0;
					r.len   = '0;
					r.ovf   = 1'b0;
				end else begin
					r.err = 1'b1;
				end
			end else if (c == CH_SEMI) begin
				if (s.phase != PH_JUMP) begin
					lk      = comp_lookup(key_of(s));
					r.comp  = (lk.hit && !s.ovf) ? lk.code : 7'd0;
					r.err   = s.err | !(lk.hit && !s.ovf);
					r.phase = PH_JUMP;
					r.tok   = '0;
					r.len   = '0;
					r.ovf   = 1'b0;
				end else begin
					r.err = 1'b1;
				end
			end else if (s.len < LEN_W'(MAX_TOKEN)) begin
				r.tok[s.len[IDX_W-1:0]] = c;
				r.len                   = s.len + LEN_W'(1);
			end else begin
				r.ovf = 1'b1;
			end
		end
		return r;
	endfunction

	pst_t        st_q, s1, s2, st_d;
	lookup_t     comp_lk, jump_lk;
	logic        pop, emit, comp_ok, jump_ok, e_a, e_c;
	logic [6:0]  comp_f;
	logic [2:0]  jump_f;
	logic [15:0] word_d;
	logic        err_d;
	logic        out_valid_q, out_error_q;
	logic [15:0] out_word_q;

	// an end-of-line word needs the output slot free or draining
	assign ev_ready = !ev.eol || !out_valid_q || out_ready;
	assign pop      = ev_valid && ev_ready;

	always_comb begin
		s1      = ev.slash ? put_char(st_q, CH_SLASH) : st_q;
		s2      = ev.chr ? put_char(s1, ev.ch) : s1;
		comp_lk = comp_lookup(key_of(s2));
		jump_lk = jump_lookup(key_of(s2));
		comp_ok = comp_lk.hit && !s2.ovf;
		jump_ok = jump_lk.hit && !s2.ovf;
		e_a     = s2.err || (s2.len == '0);
		if (s2.phase != PH_JUMP) begin
			comp_f = comp_ok ? comp_lk.code : 7'd0;
			jump_f = 3'd0;
			e_c    = s2.err || !comp_ok;
		end else begin
			comp_f = s2.comp;
			jump_f = jump_ok ? jump_lk.code[2:0] : 3'd0;
			e_c    = s2.err || !jump_ok;
		end
		if (s2.kind == KIND_A) begin
			word_d = e_a ? 16'h0000 : {1'b0, s2.addr};
			err_d  = e_a;
		end else begin
			word_d = {C_PREFIX, comp_f, s2.dest, jump_f};
			err_d  = e_c;
		end
		emit = pop && ev.eol && (s2.kind != KIND_EMPTY);
		if (!pop) begin
			st_d = st_q;
		end else if (ev.eol) begin
			st_d = '0;
		end else begin
			st_d = s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q  <= word_d;
			out_error_q <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_error = out_error_q;

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && ev.eol) |=> (st_q.kind == KIND_EMPTY && st_q.phase == PH_DEST))
		else $error("parser state not cleared after line end");

	a_out_from_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |-> $past(pop && ev.eol))
		else $error("output word appeared without a line end");

endmodule

@@ rtl/core/hack_assembly_line_encoder.sv @@
// Top level of the assembly line encoder: front end, queue and parser.
//
// Input stream: one source character per word on s_axis_tdata; s_axis_tlast
// marks a line end (its tdata is ignored). Comments starting with two
// adjacent slashes and all whitespace are dropped. Each non-empty line gives
// one 16-bit machine word on m_axis_tdata, with m_axis_tuser set when a
// mnemonic is unknown, a token is too long, an = or ; is misplaced or an
// address operand is bad. Empty lines give nothing.
// Throughput: one character per cycle while the output side keeps up; the
// front end, a two-word queue and the parser each handle one word per cycle.
// Path: an accepted line-end word is first written into the queue; the parser
// then takes it and loads the machine word into its output register.
// Stall: while m_axis_tready is low a finished word is held in the output
// register; the parser keeps taking characters and only a line end waits,
// after which the queue fills and s_axis_tready drops.
// Reset: arst_n clears comment state, parser state, queue and output valid;
// the block is ready for input straight out of reset.
module hack_assembly_line_encoder
	import hale_pkg::*;
#(
	parameter int MAX_TOKEN = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] word
	output logic        m_axis_tuser    // [0] error
);

	logic ev_valid_f, q_ready, q_valid, back_ready;
	ev_t  ev_f, ev_q;

	assign s_axis_tready = q_ready;

	hale_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (q_ready),
		.ch        (s_axis_tdata),
		.ends_line (s_axis_tlast),
		.ev_valid  (ev_valid_f),
		.ev        (ev_f)
	);

	hale_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ev_valid_f),
		.in_ready  (q_ready),
		.in_ev     (ev_f),
		.out_valid (q_valid),
		.out_ready (back_ready),
		.out_ev    (ev_q)
	);

	hale_back #(
		.MAX_TOKEN (MAX_TOKEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (q_valid),
		.ev_ready  (back_ready),
		.ev        (ev_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_error (m_axis_tuser)
	);

endmodule

@@ tb/line_word_checker.sv @@
// Checker for the line encoder: predicts each machine word from the accepted characters and compares.
module line_word_checker
	import hale_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [15:0] word
	input  logic        m_axis_tuser,   // [0] error
	output int          fail_count,
	output int          pending
);

	localparam int TOKEN_MAX = 3;

	typedef enum logic [1:0] {
		FLD_DEST,
		FLD_COMP,
		FLD_JUMP
	} field_t;

	typedef struct packed {
		logic [15:0] word;
		logic        err;
	} enc_word_t;

	string comp_txt [28] = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A", "D+1",
		"A+1", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A",
		"M", "!M", "-M", "M+1", "M-1", "D+M", "D-M", "M-D", "D&M", "D|M"};
	logic [6:0] comp_val [28] = '{7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F,
		7'h33, 7'h1F, 7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
		7'h70, 7'h71, 7'h73, 7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40, 7'h55};
	// index is the field code
	string dest_txt [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
	string jump_txt [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

	// key: length, then three characters padded with zeros
	logic [6:0] comp_codes [logic [26:0]];
	logic [6:0] dest_codes [logic [26:0]];
	logic [6:0] jump_codes [logic [26:0]];

	logic        in_cmt;
	logic        slash_pend;
	kind_t       kind;
	phase_t      phase;
	logic [14:0] addr;
	logic [7:0]  tok [TOKEN_MAX];
	logic [2:0]  tok_len;
	logic        tok_ovf;
	logic [2:0]  dest_c;
	logic [6:0]  comp_c;
	logic        bad;

	enc_word_t want_q [$];
	int        errs;

	function automatic logic [26:0] text_key(string s);
		logic [7:0] b [3];
		b = '{default: 8'h00};
		for (int i = 0; i < s.len(); i++)
			b[i] = s[i];
		return {3'(s.len()), b[0], b[1], b[2]};
	endfunction

	initial begin
		for (int i = 0; i < 28; i++)
			comp_codes[text_key(comp_txt[i])] = comp_val[i];
		for (int i = 0; i < 8; i++) begin
			dest_codes[text_key(dest_txt[i])] = 7'(i);
			jump_codes[text_key(jump_txt[i])] = 7'(i);
		end
	end

	function automatic void clear_tok();
		tok = '{default: 8'h00};
		tok_len = 3'd0;
		tok_ovf = 1'b0;
	endfunction

	function automatic void clear_line();
		in_cmt = 1'b0;
		slash_pend = 1'b0;
		kind = KIND_EMPTY;
		phase = PH_DEST;
		addr = '0;
		clear_tok();
		dest_c = '0;
		comp_c = '0;
		bad = 1'b0;
	endfunction

	// match the pending token against one mnemonic set; a miss flags the line
	function automatic logic [6:0] take_field(field_t f);
		logic [26:0] key;
		logic [6:0]  code;
		logic        hit;
		key = {tok_len, tok[0], tok[1], tok[2]};
		hit = 1'b0;
		code = '0;
		if (!tok_ovf) begin
			case (f)
				FLD_COMP: if (comp_codes.exists(key)) begin
					hit = 1'b1;
					code = comp_codes[key];
				end
				FLD_DEST: if (dest_codes.exists(key)) begin
					hit = 1'b1;
					code = dest_codes[key];
				end
				default: if (jump_codes.exists(key)) begin
					hit = 1'b1;
					code = jump_codes[key];
				end
			endcase
		end
		if (!hit)
			bad = 1'b1;
		clear_tok();
		return code;
	endfunction

	function automatic void feed_char(logic [7:0] c);
		if (kind == KIND_EMPTY) begin
			if (c == CH_AT) begin
				kind = KIND_A;
				return;
			end
			kind = KIND_C;
		end
		if (kind == KIND_A) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				addr = 15'(int'(addr) * 10 + int'(c - CH_ZERO));
				tok_len = 3'd1;  // at least one digit seen
			end else begin
				bad = 1'b1;
			end
			return;
		end
		if (c == CH_EQ) begin
			if (phase == PH_DEST) begin
				dest_c = 3'(take_field(FLD_DEST));
				phase = PH_COMP;
			end else begin
				bad = 1'b1;
			end
		end else if (c == CH_SEMI) begin
			if (phase != PH_JUMP) begin
				comp_c = take_field(FLD_COMP);
				phase = PH_JUMP;
			end else begin
				bad = 1'b1;
			end
		end else if (tok_len < TOKEN_MAX) begin
			tok[tok_len] = c;
			tok_len = tok_len + 3'd1;
		end else begin
			tok_ovf = 1'b1;
		end
	endfunction

	function automatic void take_in(logic [7:0] c, logic last);
		logic [2:0] jmp;
		logic       a_bad;
		enc_word_t  w;
		if (last) begin
			if (slash_pend) begin
				slash_pend = 1'b0;
				feed_char(CH_SLASH);
			end
			if (kind == KIND_A) begin
				a_bad = bad || tok_len == 3'd0;
				w.word = a_bad ? 16'h0 : {1'b0, addr};
				w.err = a_bad;
				want_q.insert(want_q.size(), w);
			end else if (kind == KIND_C) begin
				jmp = '0;
				if (phase != PH_JUMP)
					comp_c = take_field(FLD_COMP);
				else
					jmp = 3'(take_field(FLD_JUMP));
				w.word = {C_PREFIX, comp_c, dest_c, jmp};
				w.err = bad;
				want_q.insert(want_q.size(), w);
			end
			clear_line();
		end else if (!in_cmt) begin
			if (slash_pend && c == CH_SLASH) begin
				slash_pend = 1'b0;
				in_cmt = 1'b1;
			end else begin
				if (slash_pend) begin
					slash_pend = 1'b0;
					feed_char(CH_SLASH);
				end
				if (c == CH_SLASH)
					slash_pend = 1'b1;
				else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
					feed_char(c);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		enc_word_t want;
		if (!arst_n) begin
			clear_line();
			want_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					$error("word: expected none, got %h", m_axis_tdata);
					errs++;
				end else begin
					want = want_q.pop_front();
					if (m_axis_tdata !== want.word) begin
						$error("word: expected %h, got %h", want.word, m_axis_tdata);
						errs++;
					end
					if (m_axis_tuser !== want.err) begin
						$error("error: expected %b, got %b", want.err, m_axis_tuser);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_in(s_axis_tdata, s_axis_tlast);
			fail_count <= errs;
			pending <= want_q.size();
		end
	end

endmodule

@@ tb/hack_assembly_line_encoder_test.sv @@
// Top of the line encoder test: clock, reset, character stimulus, output stalls and verdict.
module hack_assembly_line_encoder_test;
	import hale_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_UNTIL = 400;   // random lines go on until this many words are sent
	localparam int HOLD_AT = 220;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_FROM = 280;
	localparam int QUIET_TO = 380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [15:0] word
	logic        m_axis_tuser;           // [0] error

	int fail_count;
	int pending;
	int chars_sent = 0;
	int cycles = 0;

	logic [7:0] line_buf [$];

	string comp_txt [28] = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A", "D+1",
		"A+1", "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A",
		"M", "!M", "-M", "M+1", "M-1", "D+M", "D-M", "M-D", "D&M", "D|M"};
	string dest_txt [8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
	string jump_txt [8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
	string junk_set = "AMDJ01=;!-+&|/@ ";

	hack_assembly_line_encoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	line_word_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[hack_assembly_line_encoder] ERROR");
			$finish;
		end
	end

	// no idling on either side inside the quiet window
	function automatic int idle_pct();
		return (chars_sent >= QUIET_FROM && chars_sent < QUIET_TO) ? 0 : 24;
	endfunction

	// output side: random stalls plus one long hold-off while input keeps coming
	initial begin : sink_side
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && chars_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= idle_pct());
			end
		end
	end

	// each cycle idles with the same odds before the word is offered
	task automatic send_word(logic [7:0] c, logic last);
		while ($urandom_range(99) < idle_pct()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
	endtask

	function automatic void add_byte(logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endfunction

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] blank_char();
		return $urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4));
	endfunction

	// line end word carries random data, which the block must ignore
	task automatic send_line();
		foreach (line_buf[i])
			send_word(line_buf[i], 1'b0);
		send_word(8'($urandom_range(255)), 1'b1);
		line_buf.delete();
	endtask

	task automatic directed_line(string s);
		add_text(s);
		send_line();
	endtask

	task automatic random_line();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 25) begin
			add_text("@");
			n = $urandom_range(1, 6);
			repeat (n) add_byte(8'(CH_ZERO + $urandom_range(9)));
		end else if (pick < 80) begin
			if ($urandom_range(1)) begin
				add_text(dest_txt[$urandom_range(1, 7)]);
				add_text("=");
			end
			add_text(comp_txt[$urandom_range(27)]);
			if ($urandom_range(1)) begin
				add_text(";");
				add_text(jump_txt[$urandom_range(1, 7)]);
			end
		end else if (pick < 90) begin
			n = $urandom_range(0, 6);
			repeat (n) add_byte(8'($urandom_range(255)));
		end else if (pick < 95) begin
			n = $urandom_range(1, 6);
			repeat (n) add_byte(junk_set[$urandom_range(junk_set.len() - 1)]);
		end
		if (line_buf.size() > 0 && $urandom_range(9) == 0)
			line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
		if ($urandom_range(4) == 0)
			line_buf.insert($urandom_range(line_buf.size()), blank_char());
		if ($urandom_range(7) == 0) begin
			add_text("//@1=;");
			add_byte(8'($urandom_range(255)));
		end
		send_line();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_line("@0");
		directed_line("@32767");
		directed_line("@40000");
		directed_line("@");
		directed_line("@12a");
		directed_line("AMD=D|M;JMP");
		directed_line(" \tD ;\vJGT\r");
		directed_line("D=");
		directed_line(";JMP");
		directed_line("0;JMP");
		directed_line("X=M+1");
		directed_line("M=D+1//x=@;");
		directed_line("D=A/");
		directed_line("D/A");
		directed_line("DDDD=1");
		directed_line("A=D=1");
		directed_line("D;JGT;JMP");
		directed_line("0;JGT=");
		directed_line("");
		directed_line("// @5");
		add_byte(8'h00);
		add_byte(8'hFF);
		send_line();
		directed_line("MD=!A;JNE");
		directed_line("AD=M-D;JXX");

		while (chars_sent < RANDOM_UNTIL)
			random_line();

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[hack_assembly_line_encoder] OK");
		else
			$display("[hack_assembly_line_encoder] ERROR");
		$finish;
	end

endmodule
